[rtl/gkg_pkg.sv]
// gkg_pkg: shared constants, types and helper functions of the gaussian kernel generator
`default_nettype none
package gkg_pkg;

	localparam int MAX_TAPS    = 63;
	localparam int MIN_TAPS    = 3;
	localparam int MIN_ODD     = MIN_TAPS | 1;
	localparam int MAX_ODD     = (MAX_TAPS % 2 == 0) ? MAX_TAPS - 1 : MAX_TAPS;
	localparam int FIXED_TAPS  = 3;
	localparam int IDX_W       = 6;
	localparam int CUT_W       = 12;
	localparam int SIG_W       = 16;
	localparam int COEF_W      = 24;
	localparam int TAP_W       = 40;
	localparam int SUM_W       = 48;
	localparam int DIV_W       = 64;
	localparam int DEN_W       = 48;
	localparam int STEP_W      = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam int EXP_TERMS   = 13;

	localparam logic [CUT_W-1:0]  CUTOFF_RESET = 12'd768;
	localparam logic [31:0]       EXP_M1       = 32'd1580030169;
	localparam logic [TAP_W-1:0]  TAP_LIMIT    = 40'h7F_FFFF_FFFF;
	localparam logic [TAP_W-1:0]  ONE_Q22      = 40'h00_0040_0000;
	localparam logic [TAP_W-1:0]  HALF_Q22     = 40'h00_0020_0000;
	localparam logic [TAP_W-1:0]  TWO_Q22      = 40'h00_0080_0000;

	localparam logic [STEP_W-1:0] A_STEPS    = 7'd42;
	localparam logic [STEP_W-1:0] P_STEPS    = 7'd49;
	localparam logic [STEP_W-1:0] FULL_STEPS = 7'd64;

	typedef enum logic [1:0] {
		KIND_SMOOTH = 2'd0,
		KIND_D1     = 2'd1,
		KIND_D2     = 2'd2
	} kind_t;

	typedef struct packed {
		logic [SIG_W-1:0] sigma;
		logic [IDX_W-1:0] n;
		kind_t            kind;
		logic             norm;
	} job_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  num;
		logic [DEN_W-1:0]  den;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GSET,
		ST_GDIVA,
		ST_EMUL,
		ST_EDIV,
		ST_EWAIT,
		ST_EPOW,
		ST_EPOWR,
		ST_GTAP,
		ST_GDIVP,
		ST_MLO,
		ST_MHI,
		ST_MSUM,
		ST_GDIV2,
		ST_ZGEN,
		ST_SRD,
		ST_SACC,
		ST_DSEL,
		ST_ORD,
		ST_OCALC,
		ST_ODIV,
		ST_OFMT
	} back_state_t;

	// clip a magnitude to the tap range and apply the sign
	function automatic logic signed [TAP_W-1:0] clamp_tap(input logic [DIV_W-1:0] mag,
			input logic neg);
		logic [TAP_W-1:0] m;
		m = (mag > DIV_W'(TAP_LIMIT)) ? TAP_LIMIT : mag[TAP_W-1:0];
		return neg ? -signed'(m) : signed'(m);
	endfunction

	// reciprocal of a series term index, floor(2^(32+l)/k)+1 with l = ceil(log2 k)
	function automatic logic [32:0] recip_k(input logic [3:0] k);
		logic [32:0] m;
		case (k)
			4'd1, 4'd2, 4'd4, 4'd8: m = 33'd4294967297;
			4'd3, 4'd6, 4'd12:      m = 33'd5726623062;
			4'd5, 4'd10:            m = 33'd6871947674;
			4'd7:                   m = 33'd4908534053;
			4'd9:                   m = 33'd7635497416;
			4'd11:                  m = 33'd6247225158;
			4'd13:                  m = 33'd5286113596;
			default:                m = '0;
		endcase
		return m;
	endfunction

	// quotient from the reciprocal product of a 32-bit value
	function automatic logic [32:0] recip_quot(input logic [64:0] p, input logic [3:0] k);
		logic [32:0] q;
		if (k == 4'd1) q = p[64:32];
		else if (k == 4'd2) q = {1'b0, p[64:33]};
		else if (k inside {[4'd3:4'd4]}) q = {2'b0, p[64:34]};
		else if (k inside {[4'd5:4'd8]}) q = {3'b0, p[64:35]};
		else q = {4'b0, p[64:36]};
		return q;
	endfunction

	// fixed kernels for zero sigma
	function automatic logic signed [TAP_W-1:0] zero_tap(input kind_t k,
			input logic [IDX_W-1:0] i, input logic [IDX_W-1:0] c);
		logic signed [TAP_W-1:0] v;
		v = '0;
		case (k)
			KIND_SMOOTH: begin
				v = (i == c) ? signed'(ONE_Q22) : '0;
			end
			KIND_D1: begin
				if (i < c) v = -signed'(HALF_Q22);
				else if (i == c) v = '0;
				else v = signed'(HALF_Q22);
			end
			KIND_D2: begin
				v = (i == c) ? -signed'(TWO_Q22) : signed'(ONE_Q22);
			end
			default: begin
				v = '0;
			end
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[rtl/gkg_if.sv]
// gkg_if: handshake channel interfaces for requests, taps and the cutoff register
`default_nettype none
interface gkg_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] sigma;
	logic [5:0]  requested_taps;
	logic [1:0]  kind;
	logic        normalize_enable;
	modport source (output valid, sigma, requested_taps, kind, normalize_enable, input ready);
	modport sink (input valid, sigma, requested_taps, kind, normalize_enable, output ready);
endinterface

interface gkg_tap_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] coefficient;
	logic [5:0]         tap_index;
	logic               last_tap;
	logic               saturated;
	modport source (output valid, coefficient, tap_index, last_tap, saturated, input ready);
	modport sink (input valid, coefficient, tap_index, last_tap, saturated, output ready);
endinterface

interface gkg_cfg_if;
	logic        valid;
	logic        ready;
	logic [11:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/gkg_front.sv]
// gkg_front: request intake, cutoff register and tap count
`default_nettype none
module gkg_front (
	input  logic          clk,
	input  logic          arst_n,
	gkg_req_if.sink       req,
	gkg_cfg_if.sink       cfg,
	output logic          push,
	output gkg_pkg::job_t push_job,
	input  logic          full
);
	import gkg_pkg::*;

	logic [CUT_W-1:0] cutoff_q;
	logic [27:0]      prod;
	logic [12:0]      half;
	logic [13:0]      n_raw;
	logic [13:0]      n_odd;
	logic [13:0]      n_fit;

	assign cfg.ready = 1'b1;
	assign req.ready = !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
		end else if (cfg.valid) begin
			cutoff_q <= cfg.data;
		end
	end

	always_comb begin
		prod = 28'(cutoff_q) * 28'(req.sigma);
		half = 13'((29'(prod) + 29'h0_FFFF) >> 16);
		if (req.requested_taps != '0) begin
			n_raw = 14'(req.requested_taps);
		end else if (req.sigma == '0) begin
			n_raw = 14'(MIN_TAPS);
		end else begin
			n_raw = {half, 1'b1};
		end
		n_odd = n_raw | 14'd1;
		if (n_odd < 14'(MIN_TAPS)) begin
			n_fit = 14'(MIN_ODD);
		end else if (n_odd > 14'(MAX_TAPS)) begin
			n_fit = 14'(MAX_ODD);
		end else begin
			n_fit = n_odd;
		end
		push_job.sigma = req.sigma;
		push_job.kind  = kind_t'(req.kind);
		push_job.norm  = req.normalize_enable && (req.sigma != '0);
		if (req.sigma == '0 && req.kind != KIND_SMOOTH) begin
			push_job.n = IDX_W'(FIXED_TAPS);
		end else begin
			push_job.n = n_fit[IDX_W-1:0];
		end
	end

	// unused kind code is dropped here
	assign push = req.valid && req.ready && (req.kind inside {KIND_SMOOTH, KIND_D1, KIND_D2});

endmodule
`default_nettype wire

[rtl/gkg_queue.sv]
// gkg_queue: short job queue between front and back
`default_nettype none
module gkg_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gkg_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output gkg_pkg::job_t pop_job,
	output logic          empty
);
	import gkg_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t                 ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_q;
	logic [PTR_W-1:0]     rd_q;
	logic [PTR_W:0]       cnt_q;

	assign full    = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_job;
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");
	assert property (@(posedge clk) disable iff (!arst_n) (push && !pop) |=> !empty)
		else $error("queue lost an item");

endmodule
`default_nettype wire

[rtl/gkg_div.sv]
// gkg_div: shared restoring divider, one quotient bit per cycle
`default_nettype none
module gkg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gkg_pkg::div_req_t req,
	output gkg_pkg::div_rsp_t rsp
);
	import gkg_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DEN_W:0]    rem_sh;
	logic [DEN_W:0]    rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	assign rsp.busy = run_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num << (STEP_W'(DIV_W) - req.steps);
		end else if (run_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) run_q |-> (cnt_q != '0))
		else $error("divider running with no steps left");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !run_q)
		else $error("divider done while running");
	assert property (@(posedge clk) disable iff (!arst_n) req.start |=> run_q)
		else $error("divider did not start");

endmodule
`default_nettype wire

[rtl/gkg_back.sv]
// gkg_back: tap evaluation sequencer, tap memory, sums and output conversion
`default_nettype none
module gkg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  gkg_pkg::job_t     pop_job,
	output logic              pop,
	gkg_tap_if.source         tap,
	output gkg_pkg::div_req_t dreq,
	input  gkg_pkg::div_rsp_t drsp
);
	import gkg_pkg::*;

	back_state_t state_q, state_d;

	logic [SIG_W-1:0]        sigma_q;
	logic [IDX_W-1:0]        n_q;
	kind_t                   kind_q;
	logic                    norm_q;
	logic [31:0]             s2_q;
	logic [IDX_W-1:0]        i_q, i_d;
	logic [4:0]              ax_q;
	logic [9:0]              xx_q;
	logic                    xneg_q;
	logic [32:0]             t_q, s_q, g_q;
	logic [31:0]             f_q;
	logic [3:0]              k_q;
	logic [4:0]              pw_q;
	logic [48:0]             p_q;
	logic [63:0]             acc_q;
	logic [64:0]             prod_q;
	logic [SUM_W-1:0]        psum_q, nsum_q;
	logic signed [SUM_W-1:0] rsum_q, d_q;
	logic [56:0]             mag_q;
	logic                    neg_q;
	logic signed [TAP_W-1:0] tap_mem_q [MAX_TAPS];
	logic signed [TAP_W-1:0] rd_q;
	logic                    out_valid_q, last_q, sat_q;
	logic signed [COEF_W-1:0] coef_q;
	logic [IDX_W-1:0]        idx_q;

	logic [IDX_W-1:0]        center, last_i;
	logic [4:0]              ax_c;
	logic [9:0]              xx_c;
	logic [31:0]             xs_c, dm_c, opa;
	logic                    xs_lt;
	logic [32:0]             mul_a;
	logic [31:0]             mul_b;
	logic [64:0]             mul_p;
	logic [63:0]             m64;
	logic [32:0]             tnew;
	logic                    wr_en, tap_done, out_load;
	logic signed [TAP_W-1:0] wr_data;
	logic [TAP_W-1:0]        tmag;
	logic                    tneg;
	logic [SUM_W-1:0]        dmag;
	logic                    sat_n, sat_p;
	logic [COEF_W-1:0]       m24;

	assign center = {1'b0, n_q[IDX_W-1:1]};
	assign last_i = n_q - 1'b1;
	assign ax_c   = (i_q >= center) ? 5'(i_q - center) : 5'(center - i_q);
	assign xx_c   = 10'(ax_c) * 10'(ax_c);
	assign xs_c   = 32'({xx_q, 16'b0});
	assign xs_lt  = xs_c < s2_q;
	assign dm_c   = xs_lt ? s2_q - xs_c : xs_c - s2_q;
	assign opa    = (kind_q == KIND_D1) ? 32'(ax_q) : dm_c;
	assign mul_p  = 65'(mul_a) * 65'(mul_b);
	assign m64    = acc_q + {prod_q[31:0], 32'b0};
	assign tnew   = recip_quot(prod_q, k_q);
	assign tneg   = rd_q[TAP_W-1];
	assign tmag   = tneg ? unsigned'(-rd_q) : unsigned'(rd_q);
	assign dmag   = d_q[SUM_W-1] ? unsigned'(-d_q) : unsigned'(d_q);
	assign sat_n  = neg_q && (mag_q > 57'h80_0000);
	assign sat_p  = !neg_q && (mag_q > 57'h7F_FFFF);
	assign m24    = sat_n ? 24'h80_0000 : (sat_p ? 24'h7F_FFFF : mag_q[COEF_W-1:0]);

	assign tap.valid       = out_valid_q;
	assign tap.coefficient = coef_q;
	assign tap.tap_index   = idx_q;
	assign tap.last_tap    = last_q;
	assign tap.saturated   = sat_q;

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		pop      = 1'b0;
		dreq     = '0;
		wr_en    = 1'b0;
		wr_data  = '0;
		tap_done = 1'b0;
		out_load = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					i_d     = '0;
					state_d = (pop_job.sigma == '0) ? ST_ZGEN : ST_GSET;
				end
			end
			ST_GSET: begin
				dreq.start = 1'b1;
				dreq.num   = 64'({xx_c, 31'b0}) + 64'(s2_q >> 1);
				dreq.den   = DEN_W'(s2_q);
				dreq.steps = A_STEPS;
				state_d    = ST_GDIVA;
			end
			ST_GDIVA: begin
				if (drsp.done) state_d = (drsp.quot[63:21] != '0) ? ST_GTAP : ST_EMUL;
			end
			ST_EMUL: begin
				mul_a   = t_q;
				mul_b   = f_q;
				state_d = ST_EDIV;
			end
			ST_EDIV: begin
				mul_a   = recip_k(k_q);
				mul_b   = prod_q[63:32];
				state_d = ST_EWAIT;
			end
			ST_EWAIT: begin
				state_d = (k_q == 4'(EXP_TERMS)) ? ST_EPOW : ST_EMUL;
			end
			ST_EPOW: begin
				if (pw_q == '0) begin
					state_d = ST_GTAP;
				end else begin
					mul_a   = s_q;
					mul_b   = EXP_M1;
					state_d = ST_EPOWR;
				end
			end
			ST_EPOWR: begin
				state_d = ST_EPOW;
			end
			ST_GTAP: begin
				if (kind_q == KIND_SMOOTH) begin
					wr_en    = 1'b1;
					wr_data  = clamp_tap((64'(g_q) + 64'd512) >> 10, 1'b0);
					tap_done = 1'b1;
				end else begin
					dreq.start = 1'b1;
					dreq.num   = 64'({g_q, 16'b0}) + 64'(s2_q >> 1);
					dreq.den   = DEN_W'(s2_q);
					dreq.steps = P_STEPS;
					state_d    = ST_GDIVP;
				end
			end
			ST_GDIVP: begin
				if (drsp.done) state_d = ST_MLO;
			end
			ST_MLO: begin
				mul_a   = 33'(opa);
				mul_b   = p_q[31:0];
				state_d = ST_MHI;
			end
			ST_MHI: begin
				mul_a   = 33'(opa);
				mul_b   = 32'(p_q[48:32]);
				state_d = ST_MSUM;
			end
			ST_MSUM: begin
				if (kind_q == KIND_D1) begin
					wr_en    = 1'b1;
					wr_data  = clamp_tap((m64 + 64'd512) >> 10, xneg_q);
					tap_done = 1'b1;
				end else begin
					dreq.start = 1'b1;
					dreq.num   = m64 + 64'({s2_q, 9'b0});
					dreq.den   = DEN_W'({s2_q, 10'b0});
					dreq.steps = FULL_STEPS;
					state_d    = ST_GDIV2;
				end
			end
			ST_GDIV2: begin
				if (drsp.done) begin
					wr_en    = 1'b1;
					wr_data  = clamp_tap(drsp.quot, xs_lt);
					tap_done = 1'b1;
				end
			end
			ST_ZGEN: begin
				wr_en    = 1'b1;
				wr_data  = zero_tap(kind_q, i_q, center);
				tap_done = 1'b1;
			end
			ST_SRD: begin
				state_d = ST_SACC;
			end
			ST_SACC: begin
				if (i_q == last_i) begin
					i_d     = '0;
					state_d = ST_DSEL;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_SRD;
				end
			end
			ST_DSEL: begin
				state_d = ST_ORD;
			end
			ST_ORD: begin
				state_d = ST_OCALC;
			end
			ST_OCALC: begin
				if (d_q != '0) begin
					dreq.start = 1'b1;
					dreq.num   = 64'({tmag, 16'b0}) + 64'(dmag >> 1);
					dreq.den   = dmag;
					dreq.steps = FULL_STEPS;
					state_d    = ST_ODIV;
				end else begin
					state_d = ST_OFMT;
				end
			end
			ST_ODIV: begin
				if (drsp.done) state_d = ST_OFMT;
			end
			ST_OFMT: begin
				if (!out_valid_q || tap.ready) begin
					out_load = 1'b1;
					if (i_q == last_i) begin
						i_d     = '0;
						state_d = ST_IDLE;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = ST_ORD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (tap_done) begin
			if (i_q == last_i) begin
				i_d     = '0;
				state_d = ST_SRD;
			end else begin
				i_d     = i_q + 1'b1;
				state_d = (sigma_q == '0) ? ST_ZGEN : ST_GSET;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			out_valid_q <= 1'b0;
			psum_q      <= '0;
			nsum_q      <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (tap.ready) out_valid_q <= 1'b0;
			if (tap_done && i_q == last_i) begin
				psum_q <= '0;
				nsum_q <= '0;
			end else if (state_q == ST_SACC) begin
				if (rd_q > 0) psum_q <= psum_q + SUM_W'(unsigned'(rd_q));
				else nsum_q <= nsum_q + SUM_W'(unsigned'(-rd_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q   <= tap_mem_q[i_q];
		prod_q <= mul_p;
		if (wr_en) tap_mem_q[i_q] <= wr_data;
		if (tap_done && i_q == last_i) rsum_q <= '0;
		if (out_load) begin
			coef_q <= neg_q ? -signed'(m24) : signed'(m24);
			idx_q  <= i_q;
			last_q <= (i_q == last_i);
			sat_q  <= sat_n || sat_p;
		end
		case (state_q)
			ST_IDLE: begin
				sigma_q <= pop_job.sigma;
				n_q     <= pop_job.n;
				kind_q  <= pop_job.kind;
				norm_q  <= pop_job.norm;
				s2_q    <= 32'(pop_job.sigma) * 32'(pop_job.sigma);
			end
			ST_GSET: begin
				ax_q   <= ax_c;
				xx_q   <= xx_c;
				xneg_q <= i_q < center;
			end
			ST_GDIVA: begin
				if (drsp.done) begin
					g_q  <= '0;
					pw_q <= drsp.quot[20:16];
					f_q  <= {drsp.quot[15:0], 16'b0};
					t_q  <= 33'h1_0000_0000;
					s_q  <= 33'h1_0000_0000;
					k_q  <= 4'd1;
				end
			end
			ST_EWAIT: begin
				t_q <= tnew;
				s_q <= k_q[0] ? s_q - tnew : s_q + tnew;
				k_q <= k_q + 1'b1;
			end
			ST_EPOW: begin
				if (pw_q == '0) g_q <= s_q;
			end
			ST_EPOWR: begin
				s_q  <= 33'((prod_q + 65'h8000_0000) >> 32);
				pw_q <= pw_q - 1'b1;
			end
			ST_GDIVP: begin
				if (drsp.done) p_q <= drsp.quot[48:0];
			end
			ST_MHI: begin
				acc_q <= prod_q[63:0];
			end
			ST_SACC: begin
				if (i_q > center) rsum_q <= rsum_q + SUM_W'(rd_q);
			end
			ST_DSEL: begin
				if (!norm_q) d_q <= '0;
				else if (kind_q == KIND_SMOOTH) d_q <= signed'(psum_q) - signed'(nsum_q);
				else if (kind_q == KIND_D1) d_q <= signed'((psum_q > nsum_q) ? psum_q : nsum_q);
				else d_q <= rsum_q;
			end
			ST_OCALC: begin
				if (d_q != '0) begin
					neg_q <= tneg ^ d_q[SUM_W-1];
				end else begin
					neg_q <= tneg;
					mag_q <= 57'((tmag + 40'd32) >> 6);
				end
			end
			ST_ODIV: begin
				if (drsp.done) mag_q <= drsp.quot[56:0];
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> (i_q < n_q))
		else $error("tap write beyond kernel length");
	assert property (@(posedge clk) disable iff (!arst_n) dreq.start |-> !drsp.busy)
		else $error("divider started while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && i_q == last_i) |=> (out_valid_q && last_q))
		else $error("final tap not marked last");

endmodule
`default_nettype wire

[rtl/gaussian_kernel_generator.sv]
// gaussian_kernel_generator: top level of the 1-d gaussian and derivative kernel generator
//
//  channel | dir | fields                                        | item
//  req     | in  | sigma, requested_taps, kind, normalize_enable | one kernel request
//  tap     | out | coefficient, tap_index, last_tap, saturated   | one kernel tap
//  cfg     | in  | data (cutoff)                                 | cutoff write
//
//  each tap's work is set by the shared bit-serial divider
//  (one gaussian division, one or two more for derivatives) and a 13-term series,
//  followed by a sums pass over the taps and an output conversion pass that adds
//  one division per tap with normalization
//  requests queue two deep in front of the sequencer; kind 3 is dropped on intake
//  the tap output is registered and stalls the sequencer only when still full
//  reset clears control state and sets cutoff to 3.0
`default_nettype none
module gaussian_kernel_generator (
	input  logic      clk,
	input  logic      arst_n,
	gkg_req_if.sink   req,
	gkg_tap_if.source tap,
	gkg_cfg_if.sink   cfg
);
	import gkg_pkg::*;

	logic     push, full, pop, empty;
	job_t     push_job, pop_job;
	div_req_t dreq;
	div_rsp_t drsp;

	gkg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.push     (push),
		.push_job (push_job),
		.full     (full)
	);

	gkg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	gkg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	gkg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.pop_job (pop_job),
		.pop     (pop),
		.tap     (tap),
		.dreq    (dreq),
		.drsp    (drsp)
	);

endmodule
`default_nettype wire

[test/tb_top.sv]
// tb_top: self-checking testbench for the gaussian kernel generator with a built-in tap predictor
`timescale 1ns / 1ps
module tb_top;
	import gkg_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 60_000_000;
	localparam longint unsigned TAP_MAX_MAG = 64'd549755813887;

	typedef struct {
		logic [23:0] coefficient;
		logic [5:0]  tap_index;
		logic        last_tap;
		logic        saturated;
	} tap_item_t;

	logic clk;
	logic arst_n;
	gkg_req_if req_if ();
	gkg_tap_if tap_if ();
	gkg_cfg_if cfg_if ();

	gaussian_kernel_generator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.tap    (tap_if),
		.cfg    (cfg_if)
	);

	tap_item_t       pending_taps[$];
	longint unsigned cutoff_q;
	int              errors;
	longint          cycles;
	bit              gaps_on;
	int              hold_cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic longint unsigned rdiv(longint unsigned a, longint unsigned b);
		return (a + b / 2) / b;
	endfunction

	// e^-a, a in q16.16, result q1.32
	function automatic longint unsigned gauss_q32(longint unsigned a);
		longint unsigned whole, f, t, s;
		whole = a >> 16;
		f = (a & 64'hFFFF) << 16;
		t = 64'd1 << 32;
		s = t;
		if (whole > 31) return 0;
		for (int k = 1; k <= 13; k++) begin
			t = ((t * f) >> 32) / longint'(k);
			if (k % 2 == 1) s = s - t;
			else s = s + t;
		end
		for (longint unsigned i = 0; i < whole; i++)
			s = (s * 64'(EXP_M1) + (64'd1 << 31)) >> 32;
		return s;
	endfunction

	function automatic longint clip_tap(longint unsigned mag, bit neg);
		if (mag > TAP_MAX_MAG) mag = TAP_MAX_MAG;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint tap_value(int x, longint unsigned s2, logic [1:0] k);
		longint unsigned ax, xx, g, p, xs, dm;
		ax = (x < 0) ? -x : x;
		xx = ax * ax;
		g = gauss_q32(rdiv(xx << 31, s2));
		if (k == KIND_SMOOTH) return clip_tap((g + 512) >> 10, 0);
		p = rdiv(g << 16, s2);
		if (k == KIND_D1) return clip_tap((ax * p + 512) >> 10, x < 0);
		xs = xx << 16;
		dm = (xs >= s2) ? xs - s2 : s2 - xs;
		return clip_tap(rdiv(dm * p, s2 << 10), xs < s2);
	endfunction

	function automatic int count_taps(longint unsigned sigma, longint unsigned want);
		longint unsigned n;
		if (want != 0) n = want;
		else if (sigma == 0) n = MIN_TAPS;
		else n = 2 * ((cutoff_q * sigma + 64'hFFFF) >> 16) + 1;
		if (n % 2 == 0) n++;
		if (n < MIN_TAPS) n = MIN_ODD;
		if (n > MAX_TAPS) n = MAX_ODD;
		return int'(n);
	endfunction

	task automatic kernel_expect(logic [15:0] sigma, logic [5:0] want, logic [1:0] k,
			logic norm);
		longint taps[64];
		longint unsigned psum, nsum, mag, dmag, s2;
		longint rsum, dsum, v;
		int n, center;
		bit neg, sat;
		tap_item_t e;
		psum = 0;
		nsum = 0;
		rsum = 0;
		dsum = 0;
		if (k == KIND_UNUSED) return;
		if (sigma == 0) begin
			norm = 1'b0;
			if (k == KIND_SMOOTH) begin
				n = count_taps(0, want);
				for (int i = 0; i < n; i++) taps[i] = 0;
				taps[n / 2] = 64'd1 << 22;
			end else begin
				n = 3;
				taps[0] = (k == KIND_D1) ? -(64'sd1 << 21) : (64'sd1 << 22);
				taps[1] = (k == KIND_D1) ? 0 : -(64'sd1 << 23);
				taps[2] = (k == KIND_D1) ? (64'sd1 << 21) : (64'sd1 << 22);
			end
		end else begin
			s2 = longint'(sigma) * longint'(sigma);
			n = count_taps(sigma, want);
			for (int i = 0; i < n; i++) taps[i] = tap_value(i - n / 2, s2, k);
		end
		center = n / 2;
		for (int i = 0; i < n; i++) begin
			if (taps[i] > 0) psum += taps[i];
			else nsum += -taps[i];
			if (i > center) rsum += taps[i];
		end
		if (norm) begin
			if (k == KIND_SMOOTH) dsum = longint'(psum) - longint'(nsum);
			else if (k == KIND_D1) dsum = longint'((psum > nsum) ? psum : nsum);
			else dsum = rsum;
		end
		for (int i = 0; i < n; i++) begin
			neg = taps[i] < 0;
			mag = neg ? -taps[i] : taps[i];
			sat = 0;
			if (dsum != 0) begin
				dmag = (dsum < 0) ? -dsum : dsum;
				mag = rdiv(mag << 16, dmag);
				neg = neg ^ (dsum < 0);
			end else begin
				mag = (mag + 32) >> 6;
			end
			if (neg && mag > 64'd8388608) begin
				mag = 64'd8388608;
				sat = 1;
			end else if (!neg && mag > 64'd8388607) begin
				mag = 64'd8388607;
				sat = 1;
			end
			v = neg ? -longint'(mag) : longint'(mag);
			e.coefficient = v[23:0];
			e.tap_index = i[5:0];
			e.last_tap = (i + 1 == n);
			e.saturated = sat;
			pending_taps.push_back(e);
		end
	endtask

	// tap checker
	always @(posedge clk) begin
		tap_item_t e;
		if (arst_n && tap_if.valid && tap_if.ready) begin
			if (pending_taps.size() == 0) begin
				$error("unexpected tap item index %0d", tap_if.tap_index);
				errors++;
			end else begin
				e = pending_taps.pop_front();
				if (tap_if.coefficient !== e.coefficient) begin
					$error("coefficient expected %0d actual %0d", $signed(e.coefficient),
						tap_if.coefficient);
					errors++;
				end
				if (tap_if.tap_index !== e.tap_index) begin
					$error("tap_index expected %0d actual %0d", e.tap_index, tap_if.tap_index);
					errors++;
				end
				if (tap_if.last_tap !== e.last_tap) begin
					$error("last_tap expected %0d actual %0d", e.last_tap, tap_if.last_tap);
					errors++;
				end
				if (tap_if.saturated !== e.saturated) begin
					$error("saturated expected %0d actual %0d", e.saturated, tap_if.saturated);
					errors++;
				end
			end
		end
	end

	// tap receiver stalls
	initial begin
		int stall;
		stall = 0;
		tap_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				tap_if.ready = 1'b0;
			end else if (!gaps_on) begin
				tap_if.ready = 1'b1;
			end else if (stall > 0) begin
				stall--;
				tap_if.ready = 1'b0;
			end else begin
				tap_if.ready = 1'b1;
				if ($urandom_range(3) == 0)
					stall = ($urandom_range(19) == 0) ? $urandom_range(80, 20) : $urandom_range(3);
			end
		end
	end

	task automatic send_req(logic [15:0] sigma, logic [5:0] want, logic [1:0] k, logic norm);
		int gap;
		req_if.valid = 1'b1;
		req_if.sigma = sigma;
		req_if.requested_taps = want;
		req_if.kind = k;
		req_if.normalize_enable = norm;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		kernel_expect(sigma, want, k, norm);
		@(negedge clk);
		if (gaps_on && $urandom_range(2) == 0) begin
			gap = ($urandom_range(15) == 0) ? $urandom_range(60, 10) : $urandom_range(1, 3);
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drain();
		if (req_if.valid) req_if.valid = 1'b0;
		while (pending_taps.size() != 0) @(negedge clk);
		repeat (700) @(negedge clk);
	endtask

	task automatic write_cutoff(logic [11:0] value);
		wait_drain();
		cfg_if.valid = 1'b1;
		cfg_if.data = value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cutoff_q = value;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic test_fixed_kernels();
		send_req(16'd0, 6'd0, KIND_SMOOTH, 1'b1);
		send_req(16'd0, 6'd63, KIND_SMOOTH, 1'b0);
		send_req(16'd0, 6'd4, KIND_D1, 1'b1);
		send_req(16'd0, 6'd0, KIND_D2, 1'b0);
	endtask

	task automatic test_extremes();
		for (int k = 0; k < 3; k++) begin
			send_req(16'd1, 6'd3, k[1:0], 1'b0);
			send_req(16'd1, 6'd5, k[1:0], 1'b1);
			send_req(16'hFFFF, 6'd3, k[1:0], 1'b1);
		end
		send_req(16'd2560, 6'd62, KIND_D1, 1'b1);
		send_req(16'd256, 6'd1, KIND_D2, 1'b1);
		send_req(16'd300, 6'd2, KIND_SMOOTH, 1'b1);
		send_req(16'd256, 6'd0, KIND_D2, 1'b0);
		send_req(16'd777, 6'd0, KIND_UNUSED, 1'b1);
		send_req(16'hFFFF, 6'd0, KIND_SMOOTH, 1'b1);
	endtask

	task automatic test_cutoff_settings();
		logic [11:0] values[4] = '{12'd4095, 12'd1, 12'd0, 12'd2048};
		foreach (values[i]) begin
			write_cutoff(values[i]);
			send_req(16'd64, 6'd0, KIND_SMOOTH, 1'b1);
			send_req(16'd1000, 6'd0, KIND_D1, 1'b0);
		end
		write_cutoff(CUTOFF_RESET);
	endtask

	task automatic test_backpressure();
		wait_drain();
		gaps_on = 0;
		hold_cycles = 6000;
		for (int i = 0; i < 6; i++) send_req(16'(256 + i), 6'd5, 2'(i % 3), 1'(i % 2));
		wait_drain();
		gaps_on = 1;
	endtask

	task automatic random_request();
		logic [15:0] sigma;
		logic [5:0] want;
		logic [1:0] k;
		int pick;
		k = ($urandom_range(19) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
		pick = $urandom_range(99);
		if (pick < 35) begin
			sigma = 16'($urandom);
			want = 6'($urandom_range(1, 9));
		end else if (pick < 75) begin
			sigma = 16'($urandom_range(1, 700));
			want = 0;
		end else if (pick < 95) begin
			sigma = 0;
			want = 6'($urandom_range(0, 63));
		end else begin
			sigma = 16'($urandom);
			want = 6'($urandom_range(0, 63));
		end
		send_req(sigma, want, k, 1'($urandom_range(1)));
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 4; phase++) begin
			if (phase > 0) write_cutoff(12'($urandom_range(1, 4095)));
			gaps_on = (phase != 2);
			repeat (95) random_request();
		end
		gaps_on = 1;
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.sigma = '0;
		req_if.requested_taps = '0;
		req_if.kind = '0;
		req_if.normalize_enable = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		cutoff_q = CUTOFF_RESET;
		errors = 0;
		cycles = 0;
		gaps_on = 1;
		hold_cycles = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_fixed_kernels();
		test_extremes();
		test_cutoff_settings();
		test_backpressure();
		test_random();
		wait_drain();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
